/* hdl/ftc_pkg.sv */
package ftc_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepW = $clog2(CordicSteps);
  localparam int unsigned InvGainQ16 = 39797;
  localparam int unsigned DataW = 40;
  localparam int unsigned AngW = 20;

  typedef logic signed [DataW-1:0] cval_t;
  typedef logic signed [AngW-1:0] ang_t;

  typedef struct packed {
    logic load_vec;
    logic load_rot;
    logic step;
    logic mode_rot;
    logic finish;
  } ftc_cmd_t;

  typedef struct packed {
    logic skip;
  } ftc_sts_t;

  function automatic ang_t atan_lut(input logic [StepW-1:0] i);
    ang_t r;
    case (i)
      0: r = ang_t'(51472);
      1: r = ang_t'(30385);
      2: r = ang_t'(16055);
      3: r = ang_t'(8150);
      4: r = ang_t'(4091);
      5: r = ang_t'(2047);
      6: r = ang_t'(1024);
      7: r = ang_t'(512);
      8: r = ang_t'(256);
      9: r = ang_t'(128);
      10: r = ang_t'(64);
      11: r = ang_t'(32);
      12: r = ang_t'(16);
      13: r = ang_t'(8);
      14: r = ang_t'(4);
      15: r = ang_t'(2);
      16: r = ang_t'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/ftc_ctrl.sv */
module ftc_ctrl import ftc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ftc_sts_t         sts_i,
  output ftc_cmd_t         cmd_o,
  output logic [StepW-1:0] step_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StVec  = 3'd1;
  localparam logic [2:0] StRot  = 3'd2;
  localparam logic [2:0] StFin  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic last;

  assign last = (step_q == StepW'(CordicSteps - 1));
  assign step_o = step_q;
  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    cmd_o = '0;
    cmd_o.mode_rot = (state_q == StRot);
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_vec = 1'b1;
          step_d = '0;
          state_d = StVec;
        end
      end
      StVec: begin
        if (sts_i.skip) begin
          cmd_o.finish = 1'b1;
          state_d = StOut;
        end else begin
          cmd_o.step = 1'b1;
          step_d = step_q + 1'b1;
          if (last) begin
            step_d = '0;
            state_d = StRot;
          end
        end
      end
      StRot: begin
        cmd_o.step = 1'b1;
        step_d = step_q + 1'b1;
        if (last) begin
          step_d = '0;
          state_d = StFin;
        end
      end
      StFin: begin
        cmd_o.finish = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    cmd_o.load_rot = (state_q == StVec) && !sts_i.skip && last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
    end
  end

endmodule

/* hdl/ftc_dp.sv */
module ftc_dp import ftc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [11:0]        radius_i,
  input  logic signed [15:0] own_x_i,
  input  logic signed [15:0] own_y_i,
  input  logic signed [15:0] leader_x_i,
  input  logic signed [15:0] leader_y_i,
  input  ftc_cmd_t           cmd_i,
  input  logic [StepW-1:0]   step_i,
  output ftc_sts_t           sts_o,
  output logic signed [15:0] goal_x_o,
  output logic signed [15:0] goal_y_o,
  output logic               updated_o
);

  cval_t x_q, y_q;
  ang_t z_q;
  logic signed [15:0] ox_q, lx_q, ly_q;
  logic skip_q, upd_q;
  logic signed [15:0] hx_q, hy_q;

  logic signed [16:0] dx, dy, ndy;
  cval_t xs, ys, xn, yn, rc_v, rs_v;
  ang_t zn, at;
  logic dir_pos;
  cval_t lxs, lys, c1x, c1y, c2x, c2y;
  logic signed [23:0] t1x, t1y, t2x, t2y, e1, e2, a1, a2, sx, sy;

  assign dx = 17'(leader_x_i) - 17'(own_x_i);
  assign dy = 17'(leader_y_i) - 17'(own_y_i);
  assign ndy = dx[16] ? -dy : dy;

  assign xs = x_q >>> step_i;
  assign ys = y_q >>> step_i;
  assign at = atan_lut(step_i);
  assign dir_pos = cmd_i.mode_rot ? !z_q[AngW-1] : (y_q > 0);

  always_comb begin
    if (cmd_i.mode_rot == dir_pos) begin
      // rotation with z>=0, or vectoring with y<=0
      xn = x_q - ys;
      yn = y_q + xs;
      zn = z_q - at;
    end else begin
      xn = x_q + ys;
      yn = y_q - xs;
      zn = z_q + at;
    end
  end

  function automatic logic signed [23:0] trq(input cval_t v);
    cval_t a;
    a = v[DataW-1] ? -v : v;
    a = a >>> 16;
    return v[DataW-1] ? -a[23:0] : a[23:0];
  endfunction

  function automatic logic signed [15:0] sat(input logic signed [23:0] v);
    if (v > 24'sd32767) return 16'sh7fff;
    if (v < -24'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  assign rc_v = x_q;
  assign rs_v = y_q;
  assign lxs = cval_t'(lx_q) <<< 16;
  assign lys = cval_t'(ly_q) <<< 16;
  assign c1x = lxs - rc_v;
  assign c1y = lys - rs_v;
  assign c2x = lxs + rc_v;
  assign c2y = lys + rs_v;
  assign t1x = trq(c1x);
  assign t1y = trq(c1y);
  assign t2x = trq(c2x);
  assign t2y = trq(c2y);
  assign e1 = t1x - 24'(ox_q);
  assign e2 = t2x - 24'(ox_q);
  assign a1 = e1[23] ? -e1 : e1;
  assign a2 = e2[23] ? -e2 : e2;
  assign sx = (a1 < a2) ? t1x : t2x;
  assign sy = (a1 < a2) ? t1y : t2y;

  assign sts_o.skip = skip_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_vec) begin
      x_q <= (dx[16] ? cval_t'(-dx) : cval_t'(dx)) <<< 16;
      y_q <= cval_t'(ndy) <<< 16;
      z_q <= '0;
      ox_q <= own_x_i;
      lx_q <= leader_x_i;
      ly_q <= leader_y_i;
      skip_q <= (dx == '0) || (dy == '0);
    end else if (cmd_i.load_rot) begin
      x_q <= cval_t'(28'(radius_i) * 28'(InvGainQ16));
      y_q <= '0;
      z_q <= zn;
    end else if (cmd_i.step) begin
      x_q <= xn;
      y_q <= yn;
      z_q <= zn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hx_q <= '0;
      hy_q <= '0;
      upd_q <= 1'b0;
    end else if (cmd_i.finish) begin
      upd_q <= !skip_q;
      if (!skip_q) begin
        hx_q <= sat(sx);
        hy_q <= sat(sy);
      end
    end
  end

  assign goal_x_o = hx_q;
  assign goal_y_o = hy_q;
  assign updated_o = upd_q;

endmodule

/* hdl/follow_target_on_circle.sv */
// Picks a point at the configured radius from the leader on the line through
// both robots, using one shared CORDIC stage for the vectoring and rotation
// passes. When a coordinate difference is zero, both passes are skipped, the
// previous goal is kept and updated_o is low. The result is held until
// transferred, then the next item is taken.
module follow_target_on_circle import ftc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [11:0]        keep_dist_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] own_x_i,
  input  logic signed [15:0] own_y_i,
  input  logic signed [15:0] leader_x_i,
  input  logic signed [15:0] leader_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] goal_x_o,
  output logic signed [15:0] goal_y_o,
  output logic               updated_o
);

  logic [11:0] radius_q;
  ftc_cmd_t cmd;
  ftc_sts_t sts;
  logic [StepW-1:0] step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) radius_q <= '0;
    else if (cfg_valid_i) radius_q <= keep_dist_i;
  end

  ftc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd), .step_o(step)
  );

  ftc_dp u_dp (
    .clk_i, .rst_ni, .radius_i(radius_q), .own_x_i, .own_y_i,
    .leader_x_i, .leader_y_i, .cmd_i(cmd), .step_i(step), .sts_o(sts),
    .goal_x_o, .goal_y_o, .updated_o
  );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ftc_pkg::*;

  typedef struct packed {
    logic signed [15:0] own_x;
    logic signed [15:0] own_y;
    logic signed [15:0] leader_x;
    logic signed [15:0] leader_y;
  } pos_item_t;

  typedef struct packed {
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic               upd;
  } target_t;

  localparam int unsigned SettleCycles = 80;
  localparam int unsigned WatchdogLimit = 20000;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [11:0] cfg_radius;
  logic in_valid, in_ready;
  logic signed [15:0] own_x, own_y, leader_x, leader_y;
  logic out_valid, out_ready;
  logic signed [15:0] goal_x, goal_y;
  logic updated;

  pos_item_t pending_pos[$];
  target_t   expected_targets[$];
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned stall_count;
  bit          failed;
  bit          cfg_req;
  logic [11:0] cfg_req_val;

  logic [11:0]        radius_mdl;
  logic signed [15:0] held_x_mdl, held_y_mdl;

  follow_target_on_circle DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .keep_dist_i(cfg_radius),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .own_x_i(own_x), .own_y_i(own_y), .leader_x_i(leader_x), .leader_y_i(leader_y),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .goal_x_o(goal_x), .goal_y_o(goal_y), .updated_o(updated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint trunc_frac(longint v);
    if (v >= 0) return v >>> 16;
    return -((-v) >>> 16);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint arctan_step(int i);
    longint lut[17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2, 1};
    return i < 17 ? lut[i] : 0;
  endfunction

  function automatic target_t predict_target(pos_item_t p);
    target_t r;
    longint ox, oy, lx, ly, dx, dy, x, y, z, xs, ys, rc, rs;
    longint c1x, c1y, c2x, c2y;
    ox = p.own_x; oy = p.own_y; lx = p.leader_x; ly = p.leader_y;
    dx = lx - ox;
    dy = ly - oy;
    r.upd = 1'b0;
    if (dx != 0 && dy != 0) begin
      x = magnitude(dx) * 65536;
      y = (dx < 0 ? -dy : dy) * 65536;
      z = 0;
      for (int i = 0; i < CordicSteps; i++) begin
        xs = floor_shr(x, i);
        ys = floor_shr(y, i);
        if (y > 0) begin
          x += ys; y -= xs; z += arctan_step(i);
        end else begin
          x -= ys; y += xs; z -= arctan_step(i);
        end
      end
      x = longint'(radius_mdl) * InvGainQ16;
      y = 0;
      for (int i = 0; i < CordicSteps; i++) begin
        xs = floor_shr(x, i);
        ys = floor_shr(y, i);
        if (z >= 0) begin
          x -= ys; y += xs; z -= arctan_step(i);
        end else begin
          x += ys; y -= xs; z += arctan_step(i);
        end
      end
      rc = x; rs = y;
      c1x = trunc_frac(lx * 65536 - rc);
      c1y = trunc_frac(ly * 65536 - rs);
      c2x = trunc_frac(lx * 65536 + rc);
      c2y = trunc_frac(ly * 65536 + rs);
      if (magnitude(c1x - ox) < magnitude(c2x - ox)) begin
        held_x_mdl = clamp16(c1x); held_y_mdl = clamp16(c1y);
      end else begin
        held_x_mdl = clamp16(c2x); held_y_mdl = clamp16(c2y);
      end
      r.upd = 1'b1;
    end
    r.tx = held_x_mdl;
    r.ty = held_y_mdl;
    return r;
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      own_x <= '0; own_y <= '0; leader_x <= '0; leader_y <= '0;
      cfg_valid <= 1'b0;
      cfg_radius <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        radius_mdl = cfg_radius;
        cfg_req = 1'b0;
      end
      cfg_valid <= cfg_req && !(cfg_valid && cfg_ready);
      if (cfg_req) cfg_radius <= cfg_req_val;
      if (in_valid && in_ready) begin
        expected_targets.push_back(predict_target({own_x, own_y, leader_x, leader_y}));
        void'(pending_pos.pop_front());
      end
      if ((!in_valid || in_ready) && !cfg_req) begin
        if (pending_pos.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          {own_x, own_y, leader_x, leader_y} <= pending_pos[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk or negedge rst_n) begin
    target_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_count <= 0;
    end else begin
      out_ready <= $urandom_range(99) >= recv_idle_pct;
      if (out_valid && out_ready) begin
        if (expected_targets.size() == 0) begin
          $error("unexpected result x=%0d y=%0d", goal_x, goal_y);
          failed = 1'b1;
        end else begin
          e = expected_targets.pop_front();
          if (goal_x !== e.tx) begin
            $error("goal_x expected %0d actual %0d", e.tx, goal_x); failed = 1'b1;
          end
          if (goal_y !== e.ty) begin
            $error("goal_y expected %0d actual %0d", e.ty, goal_y); failed = 1'b1;
          end
          if (updated !== e.upd) begin
            $error("updated expected %0d actual %0d", e.upd, updated); failed = 1'b1;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_count <= 0;
      else
        stall_count <= stall_count + 1;
      if (stall_count >= WatchdogLimit) begin
        $display("FAIL follow_target_on_circle");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'sh7fff - 16'($urandom_range(50))
                                  : 16'sh8000 + 16'($urandom_range(50));
      default: return $signed(16'($urandom_range(4000))) - 16'sd2000;
    endcase
  endfunction

  task automatic queue_pos(int ox, int oy, int lx, int ly);
    pos_item_t p;
    p.own_x = 16'(ox); p.own_y = 16'(oy); p.leader_x = 16'(lx); p.leader_y = 16'(ly);
    pending_pos.push_back(p);
  endtask

  task automatic drain();
    wait (pending_pos.size() == 0 && !in_valid && expected_targets.size() == 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_radius(logic [11:0] r);
    cfg_req_val = r;
    cfg_req = 1'b1;
    wait (!cfg_req);
    @(posedge clk);
  endtask

  task automatic queue_random(int n);
    pos_item_t p;
    for (int k = 0; k < n; k++) begin
      p.own_x = rand_coord(); p.own_y = rand_coord();
      case ($urandom_range(9))
        0: begin p.leader_x = p.own_x; p.leader_y = rand_coord(); end
        1: begin p.leader_x = rand_coord(); p.leader_y = p.own_y; end
        2: begin
          p.leader_x = p.own_x + $signed(16'($urandom_range(6))) - 16'sd3;
          p.leader_y = p.own_y + $signed(16'($urandom_range(6))) - 16'sd3;
        end
        default: begin p.leader_x = rand_coord(); p.leader_y = rand_coord(); end
      endcase
      pending_pos.push_back(p);
    end
  endtask

  initial begin
    logic [11:0] radii[6] = '{12'd0, 12'd4095, 12'd1, 12'd500, 12'hAAA, 12'h555};
    failed = 1'b0;
    cfg_req = 1'b0;
    cfg_req_val = '0;
    radius_mdl = '0;
    held_x_mdl = '0;
    held_y_mdl = '0;
    send_idle_pct = 25;
    recv_idle_pct = 82;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero radius, then zero differences, then extremes
    queue_pos(0, 0, 0, 0);
    queue_pos(10, 20, 30, 40);
    queue_pos(5, 5, 5, 9);
    queue_pos(5, 5, 9, 5);
    drain();
    set_radius(12'd4095);
    queue_pos(-32768, -32768, 32767, 32767);
    queue_pos(32767, 32767, -32768, -32768);
    queue_pos(32767, -32768, -32768, 32767);
    queue_pos(-32768, 32767, 32767, -32768);
    queue_pos(0, 0, 32767, 1);
    queue_pos(0, 0, -32768, -1);
    queue_pos(0, 0, 1, 32767);
    queue_pos(100, 100, 100, 300);
    queue_pos(0, 0, 3, 3);
    queue_pos(0, 0, -3, 3);
    queue_pos(-1, -1, 0, 0);
    queue_pos(30000, 30000, 30001, 30002);
    queue_pos(-30000, -30000, -30001, -30002);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle_pct = 82; recv_idle_pct = 25; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      set_radius(ph < 2 ? radii[ph] : 12'($urandom_range(4095)));
      queue_random(200);
      drain();
    end

    if (!failed)
      $display("PASS follow_target_on_circle");
    else
      $display("FAIL follow_target_on_circle");
    $finish;
  end

endmodule
